### rtl/xcr_pkg.sv
// ----------------------------------------------------------------------------
// xcr_pkg: shared types and constants of the XMODEM checksum receiver
// Frame symbols, register indexes, result kinds, the controller state type
// and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package xcr_pkg;

    localparam int PAYLOAD_BYTES = 128;
    localparam int WORDS         = PAYLOAD_BYTES / 4;
    localparam int WORD_IDX_W    = $clog2(WORDS);
    localparam int BYTE_IDX_W    = $clog2(PAYLOAD_BYTES);

    localparam logic [7:0] SYM_SOH = 8'h01;
    localparam logic [7:0] SYM_EOT = 8'h04;
    localparam logic [7:0] SYM_ACK = 8'h06;
    localparam logic [7:0] SYM_NAK = 8'h15;
    localparam logic [7:0] BLK_ALL = 8'hFF;

    localparam logic [7:0] POS_IDLE  = 8'd0;
    localparam logic [7:0] POS_BLOCK = 8'd1;
    localparam logic [7:0] POS_COMPL = 8'd2;
    localparam logic [7:0] POS_DATA  = 8'd3;
    localparam logic [7:0] POS_SUM   = 8'(3 + PAYLOAD_BYTES);

    localparam logic [31:0] TIMEOUT_RESET   = 32'd4000000;
    localparam logic [31:0] LOAD_BASE_RESET = 32'h0000_8000;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOAD_BASE = 2'd1;

    localparam logic [1:0] RK_TX    = 2'd0;
    localparam logic [1:0] RK_WORD  = 2'd1;
    localparam logic [1:0] RK_START = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_TCHK,
        S_NAK,
        S_EOT_ACK,
        S_START,
        S_RD,
        S_WORD,
        S_ACK_END,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        POS_HOLD,
        POS_CLEAR,
        POS_ADVANCE
    } t_pos_op;

    typedef enum logic [1:0] {
        SUM_HOLD,
        SUM_LOAD,
        SUM_ADD
    } t_sum_op;

    typedef enum logic [1:0] {
        OUT_NAK,
        OUT_ACK,
        OUT_START,
        OUT_WORD
    } t_out_sel;

    typedef struct packed {
        logic     accept;
        logic     tick_inc;
        logic     tick_sub;
        logic     idle_clr;
        t_pos_op  pos_op;
        t_sum_op  sum_op;
        logic     store;
        logic     blk_inc;
        logic     word_start;
        logic     word_emit;
        logic     out_load;
        t_out_sel out_sel;
        logic     out_last;
    } t_cmd;

    typedef struct packed {
        logic is_tick;
        logic pos_idle;
        logic pos_block;
        logic pos_compl;
        logic pos_sum;
        logic byte_soh;
        logic byte_eot;
        logic blk_ok;
        logic cmp_ok;
        logic sum_ok;
        logic timeout_hit;
        logic out_free;
        logic last_word;
    } t_status;

endpackage

### rtl/xcr_ram.sv
// ----------------------------------------------------------------------------
// xcr_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module xcr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/xcr_ctrl.sv
// ----------------------------------------------------------------------------
// xcr_ctrl: frame controller of the XMODEM checksum receiver
// Decides on each accepted byte or tick and sequences the replies and the
// word writes of a good block.
// ----------------------------------------------------------------------------
module xcr_ctrl
    import xcr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   in_accept;

    assign o_in_stall = !((r_state == S_IDLE) || (r_state == S_DONE));
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_status.is_tick) begin
                    n_state = S_TCHK;
                end else if (i_status.pos_idle) begin
                    if (i_status.byte_eot) begin
                        n_state = S_EOT_ACK;
                    end else if (i_status.byte_soh) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_NAK;
                    end
                end else if (i_status.pos_block) begin
                    n_state = i_status.blk_ok ? S_IDLE : S_NAK;
                end else if (i_status.pos_compl) begin
                    n_state = i_status.cmp_ok ? S_IDLE : S_NAK;
                end else if (i_status.pos_sum) begin
                    n_state = i_status.sum_ok ? S_RD : S_NAK;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_TCHK: begin
                n_state = i_status.timeout_hit ? S_NAK : S_IDLE;
            end
            S_NAK: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_EOT_ACK: begin
                if (i_status.out_free) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                if (i_status.out_free) begin
                    n_state = S_DONE;
                end
            end
            S_RD: begin
                n_state = S_WORD;
            end
            S_WORD: begin
                if (i_status.out_free && i_status.last_word) begin
                    n_state = S_ACK_END;
                end
            end
            S_ACK_END: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_DONE: begin
                n_state = S_DONE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Commands
    always_comb begin
        o_cmd            = '0;
        o_cmd.pos_op     = POS_HOLD;
        o_cmd.sum_op     = SUM_HOLD;
        o_cmd.out_sel    = OUT_NAK;
        case (r_state)
            S_IDLE: begin
                o_cmd.accept = in_accept;
            end
            S_EVAL: begin
                if (i_status.is_tick) begin
                    o_cmd.tick_inc = 1'b1;
                end else begin
                    o_cmd.idle_clr = 1'b1;
                    if (i_status.pos_idle) begin
                        if (!i_status.byte_eot && i_status.byte_soh) begin
                            o_cmd.pos_op = POS_ADVANCE;
                            o_cmd.sum_op = SUM_LOAD;
                        end
                    end else if (i_status.pos_block) begin
                        if (i_status.blk_ok) begin
                            o_cmd.pos_op = POS_ADVANCE;
                            o_cmd.sum_op = SUM_ADD;
                        end else begin
                            o_cmd.pos_op = POS_CLEAR;
                        end
                    end else if (i_status.pos_compl) begin
                        if (i_status.cmp_ok) begin
                            o_cmd.pos_op = POS_ADVANCE;
                            o_cmd.sum_op = SUM_ADD;
                        end else begin
                            o_cmd.pos_op = POS_CLEAR;
                        end
                    end else if (i_status.pos_sum) begin
                        o_cmd.pos_op     = POS_CLEAR;
                        o_cmd.blk_inc    = i_status.sum_ok;
                        o_cmd.word_start = i_status.sum_ok;
                    end else begin
                        o_cmd.pos_op = POS_ADVANCE;
                        o_cmd.sum_op = SUM_ADD;
                        o_cmd.store  = 1'b1;
                    end
                end
            end
            S_TCHK: begin
                o_cmd.tick_sub = i_status.timeout_hit;
            end
            S_NAK: begin
                o_cmd.out_load = i_status.out_free;
                o_cmd.out_sel  = OUT_NAK;
                o_cmd.out_last = 1'b1;
            end
            S_EOT_ACK: begin
                o_cmd.out_load = i_status.out_free;
                o_cmd.out_sel  = OUT_ACK;
            end
            S_START: begin
                o_cmd.out_load = i_status.out_free;
                o_cmd.out_sel  = OUT_START;
                o_cmd.out_last = 1'b1;
            end
            S_WORD: begin
                o_cmd.out_load  = i_status.out_free;
                o_cmd.word_emit = i_status.out_free;
                o_cmd.out_sel   = OUT_WORD;
            end
            S_ACK_END: begin
                o_cmd.out_load = i_status.out_free;
                o_cmd.out_sel  = OUT_ACK;
                o_cmd.out_last = 1'b1;
            end
            default: begin
                o_cmd = o_cmd;
            end
        endcase
    end

endmodule

### rtl/xcr_dp.sv
// ----------------------------------------------------------------------------
// xcr_dp: datapath of the XMODEM checksum receiver
// Holds the registers, the frame counters, the block buffer and the output
// register, and reports comparisons to the controller.
// ----------------------------------------------------------------------------
module xcr_dp
    import xcr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_kind,
    input  logic [7:0]           i_rx_byte,
    input  logic                 i_out_stall,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    output logic                 o_out_valid,
    output logic [1:0]           o_result_kind,
    output logic [7:0]           o_tx_byte,
    output logic [31:0]          o_mem_addr,
    output logic [31:0]          o_mem_word,
    output logic                 o_last
);

    logic [31:0]           r_timeout;
    logic [31:0]           r_load_base;
    logic [31:0]           r_waddr;
    logic [31:0]           r_idle;
    logic [7:0]            r_pos;
    logic [7:0]            r_sum;
    logic [7:0]            r_blk;
    logic                  r_kind;
    logic [7:0]            r_byte;
    logic [23:0]           r_wbuf;
    logic [WORD_IDX_W-1:0] r_widx;
    logic                  r_ovalid;
    logic [1:0]            r_okind;
    logic [7:0]            r_otx;
    logic [31:0]           r_oaddr;
    logic [31:0]           r_oword;
    logic                  r_olast;

    logic [32:0]           idle_diff;
    logic [7:0]            byte_off;
    logic [BYTE_IDX_W-1:0] byte_idx;
    logic                  ram_we;
    logic [WORD_IDX_W-1:0] ram_raddr;
    logic [31:0]           ram_rdata;
    logic                  out_free;

    // A single subtract gives both the timeout compare (no borrow) and the
    // remainder that is kept after a timeout.
    assign idle_diff = {1'b0, r_idle} - {1'b0, r_timeout};
    assign byte_off  = r_pos - POS_DATA;
    assign byte_idx  = byte_off[BYTE_IDX_W-1:0];
    assign ram_we    = i_cmd.store && (byte_idx[1:0] == 2'd3);
    assign ram_raddr = i_cmd.word_emit ? r_widx + WORD_IDX_W'(1) : r_widx;
    assign out_free  = !r_ovalid || !i_out_stall;

    xcr_ram #(
        .WIDTH (32),
        .DEPTH (WORDS)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (byte_idx[BYTE_IDX_W-1:2]),
        .i_wdata ({r_byte, r_wbuf}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        o_status.is_tick     = r_kind;
        o_status.pos_idle    = (r_pos == POS_IDLE);
        o_status.pos_block   = (r_pos == POS_BLOCK);
        o_status.pos_compl   = (r_pos == POS_COMPL);
        o_status.pos_sum     = (r_pos >= POS_SUM);
        o_status.byte_soh    = (r_byte == SYM_SOH);
        o_status.byte_eot    = (r_byte == SYM_EOT);
        o_status.blk_ok      = (r_byte == r_blk);
        o_status.cmp_ok      = (r_byte == (BLK_ALL - r_blk));
        o_status.sum_ok      = (r_byte == r_sum);
        o_status.timeout_hit = !idle_diff[32];
        o_status.out_free    = out_free;
        o_status.last_word   = (r_widx == WORD_IDX_W'(WORDS - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= TIMEOUT_RESET;
            r_load_base <= LOAD_BASE_RESET;
            r_waddr     <= LOAD_BASE_RESET;
            r_idle      <= '0;
            r_pos       <= POS_IDLE;
            r_sum       <= '0;
            r_blk       <= 8'd1;
            r_widx      <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            if (i_cfg_valid && (i_cfg_index == CFG_TIMEOUT)) begin
                r_timeout <= i_cfg_data;
            end
            if (i_cfg_valid && (i_cfg_index == CFG_LOAD_BASE)) begin
                r_load_base <= i_cfg_data;
                r_waddr     <= i_cfg_data;
            end else if (i_cmd.word_emit) begin
                r_waddr <= r_waddr + 32'd4;
            end

            if (i_cmd.idle_clr) begin
                r_idle <= '0;
            end else if (i_cmd.tick_inc && (r_idle != '1)) begin
                r_idle <= r_idle + 32'd1;
            end else if (i_cmd.tick_sub) begin
                r_idle <= idle_diff[31:0];
            end

            case (i_cmd.pos_op)
                POS_CLEAR:   r_pos <= POS_IDLE;
                POS_ADVANCE: r_pos <= r_pos + 8'd1;
                default:     r_pos <= r_pos;
            endcase

            case (i_cmd.sum_op)
                SUM_LOAD: r_sum <= r_byte;
                SUM_ADD:  r_sum <= r_sum + r_byte;
                default:  r_sum <= r_sum;
            endcase

            if (i_cmd.blk_inc) begin
                r_blk <= r_blk + 8'd1;
            end

            if (i_cmd.word_start) begin
                r_widx <= '0;
            end else if (i_cmd.word_emit) begin
                r_widx <= r_widx + WORD_IDX_W'(1);
            end

            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind <= i_kind;
            r_byte <= i_rx_byte;
        end
        // The first three bytes of each word gather here, lowest byte first.
        if (i_cmd.store) begin
            r_wbuf <= {r_byte, r_wbuf[23:8]};
        end
        if (i_cmd.out_load) begin
            r_olast <= i_cmd.out_last;
            case (i_cmd.out_sel)
                OUT_NAK: begin
                    r_okind <= RK_TX;
                    r_otx   <= SYM_NAK;
                    r_oaddr <= '0;
                    r_oword <= '0;
                end
                OUT_ACK: begin
                    r_okind <= RK_TX;
                    r_otx   <= SYM_ACK;
                    r_oaddr <= '0;
                    r_oword <= '0;
                end
                OUT_START: begin
                    r_okind <= RK_START;
                    r_otx   <= '0;
                    r_oaddr <= r_load_base;
                    r_oword <= '0;
                end
                default: begin
                    r_okind <= RK_WORD;
                    r_otx   <= '0;
                    r_oaddr <= r_waddr;
                    r_oword <= ram_rdata;
                end
            endcase
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_result_kind = r_okind;
    assign o_tx_byte     = r_otx;
    assign o_mem_addr    = r_oaddr;
    assign o_mem_word    = r_oword;
    assign o_last        = r_olast;

endmodule

### rtl/xmodem_checksum_receiver.sv
// ----------------------------------------------------------------------------
// xmodem_checksum_receiver: XMODEM receiver with 8-bit checksum
// Takes received bytes and timer ticks, checks frames of 128 data bytes, writes good
// blocks out as little-endian words and answers with ACK or NAK.
//
//   Channel  Direction  Handshake          Payload
//   input    in         i_in_valid/stall   i_kind, i_rx_byte
//   result   out        o_out_valid/stall  o_result_kind, o_tx_byte,
//                                          o_mem_addr, o_mem_word, o_last
//   config   in         i_cfg_valid/ready  i_cfg_index, i_cfg_data
//
// An item is taken in one cycle and decided in the next. After a good checksum
// byte, one word leaves per cycle unless the result channel stalls, paced by the
// single read port of the block buffer.
// Reset is synchronous and active low; the block buffer needs no clearing
// pass, since a word is read only after the current frame has written it.
// An output register holds each result, so a new item is taken while the
// last result still waits; a stall only pauses the sequence.
// ----------------------------------------------------------------------------
module xmodem_checksum_receiver
    import xcr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_kind,
    input  logic [7:0]           i_rx_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [1:0]           o_result_kind,
    output logic [7:0]           o_tx_byte,
    output logic [31:0]          o_mem_addr,
    output logic [31:0]          o_mem_word,
    output logic                 o_last,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    xcr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    xcr_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_kind        (i_kind),
        .i_rx_byte     (i_rx_byte),
        .i_out_stall   (i_out_stall),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_out_valid   (o_out_valid),
        .o_result_kind (o_result_kind),
        .o_tx_byte     (o_tx_byte),
        .o_mem_addr    (o_mem_addr),
        .o_mem_word    (o_mem_word),
        .o_last        (o_last)
    );

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: XMODEM checksum receiver
// Feeds received bytes and timer ticks through the input channel while the
// result channel stalls on its own pattern. A predictor of the frame logic
// works out the replies, word writes and start command for every accepted
// transaction. The results are then checked field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
    import xcr_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_HOLD    = 300;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Indexes with no register behind them; writes to these must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} t_fill;

    typedef struct {
        logic       kind;
        logic [7:0] rx;
    } t_line_item;

    typedef struct {
        logic [1:0]  rkind;
        logic [7:0]  tx;
        logic [31:0] addr;
        logic [31:0] word;
        logic        last;
    } t_xfer;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_kind   = KIND_BYTE;
    logic [7:0]           in_rx     = 8'h00;
    logic                 out_stall = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_TIMEOUT;
    logic [31:0]          cfg_data  = 32'h0;

    logic        in_stall;
    logic        out_valid;
    logic [1:0]  res_kind;
    logic [7:0]  res_tx;
    logic [31:0] res_addr;
    logic [31:0] res_word;
    logic        res_last;
    logic        cfg_ready;

    t_line_item rx_feed[$];
    t_xfer      xfer_results[$];

    bit         in_took    = 1'b0;
    int         fail_count = 0;
    int         fed_count  = 0;
    logic [7:0] blk_next   = 8'h01;

    // Predictor state
    logic [31:0] tmo_cfg    = TIMEOUT_RESET;
    logic [31:0] base_cfg   = LOAD_BASE_RESET;
    logic [7:0]  fpos       = POS_IDLE;
    logic [7:0]  blk_no     = 8'h01;
    logic [7:0]  fsum       = 8'h00;
    logic [7:0]  blk_buf [PAYLOAD_BYTES];
    logic [31:0] wr_addr    = LOAD_BASE_RESET;
    logic [31:0] idle_ticks = 32'h0;
    logic        done_flag  = 1'b0;

    int burst_left = 0;
    int gap_left   = 0;
    int hold_left  = 0;
    int holds_done = 0;
    int stall_tick = 0;
    int quiet      = 0;

    xmodem_checksum_receiver uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_kind        (in_kind),
        .i_rx_byte     (in_rx),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_result_kind (res_kind),
        .o_tx_byte     (res_tx),
        .o_mem_addr    (res_addr),
        .o_mem_word    (res_word),
        .o_last        (res_last),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void add_result(input logic [1:0] k, input logic [7:0] tx,
                                       input logic [31:0] a, input logic [31:0] w,
                                       input logic l);
        t_xfer r;
        r.rkind = k;
        r.tx    = tx;
        r.addr  = a;
        r.word  = w;
        r.last  = l;
        xfer_results.push_back(r);
    endfunction

    // Works out what one accepted transaction makes the receiver emit.
    function automatic void step_receiver(input logic kind, input logic [7:0] b);
        int w;
        if (done_flag)
            return;
        if (kind == KIND_TICK) begin
            if (idle_ticks != '1)
                idle_ticks++;
            if (idle_ticks >= tmo_cfg) begin
                idle_ticks -= tmo_cfg;
                add_result(RK_TX, SYM_NAK, 32'h0, 32'h0, 1'b1);
            end
            return;
        end
        idle_ticks = 32'h0;
        if (fpos == POS_IDLE) begin
            if (b == SYM_EOT) begin
                add_result(RK_TX, SYM_ACK, 32'h0, 32'h0, 1'b0);
                add_result(RK_START, 8'h00, base_cfg, 32'h0, 1'b1);
                done_flag = 1'b1;
            end else if (b == SYM_SOH) begin
                fsum = b;
                fpos = POS_BLOCK;
            end else begin
                add_result(RK_TX, SYM_NAK, 32'h0, 32'h0, 1'b1);
            end
        end else if (fpos == POS_BLOCK) begin
            if (b == blk_no) begin
                fsum += b;
                fpos = POS_COMPL;
            end else begin
                fpos = POS_IDLE;
                add_result(RK_TX, SYM_NAK, 32'h0, 32'h0, 1'b1);
            end
        end else if (fpos == POS_COMPL) begin
            if (b == 8'(BLK_ALL - blk_no)) begin
                fsum += b;
                fpos = POS_DATA;
            end else begin
                fpos = POS_IDLE;
                add_result(RK_TX, SYM_NAK, 32'h0, 32'h0, 1'b1);
            end
        end else if (fpos >= POS_SUM) begin
            fpos = POS_IDLE;
            if (b == fsum) begin
                for (w = 0; w < PAYLOAD_BYTES / 4; w++) begin
                    add_result(RK_WORD, 8'h00, wr_addr,
                               {blk_buf[4*w+3], blk_buf[4*w+2], blk_buf[4*w+1], blk_buf[4*w]},
                               1'b0);
                    wr_addr += 32'd4;
                end
                add_result(RK_TX, SYM_ACK, 32'h0, 32'h0, 1'b1);
                blk_no++;
            end else begin
                add_result(RK_TX, SYM_NAK, 32'h0, 32'h0, 1'b1);
            end
        end else begin
            blk_buf[7'(fpos - POS_DATA)] = b;
            fsum += b;
            fpos++;
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] got,
                                        input logic [31:0] want);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void push_item(input logic kind, input logic [7:0] b);
        t_line_item it;
        it.kind = kind;
        it.rx   = b;
        rx_feed.push_back(it);
        fed_count++;
    endfunction

    function automatic void push_rx(input logic [7:0] b);
        push_item(KIND_BYTE, b);
    endfunction

    function automatic void push_tick();
        push_item(KIND_TICK, 8'($urandom_range(0, 255)));
    endfunction

    // The checksum covers the data only, since the header sums to zero.
    function automatic void push_frame(input bit good_sum, input t_fill fill);
        logic [7:0] sum;
        logic [7:0] d;
        int i;
        sum = 8'h00;
        push_rx(SYM_SOH);
        push_rx(blk_next);
        push_rx(8'(BLK_ALL - blk_next));
        for (i = 0; i < PAYLOAD_BYTES; i++) begin
            case (fill)
                FILL_ZERO: d = 8'h00;
                FILL_ONES: d = 8'hFF;
                default: begin
                    if ($urandom_range(0, 7) == 0)
                        d = $urandom_range(0, 1) ? SYM_SOH : SYM_EOT;
                    else
                        d = 8'($urandom_range(0, 255));
                end
            endcase
            sum += d;
            push_rx(d);
            if ($urandom_range(0, 15) == 0)
                push_tick();
        end
        if (good_sum) begin
            push_rx(sum);
            blk_next++;
        end else begin
            push_rx(8'(sum + 8'($urandom_range(1, 255))));
        end
    endfunction

    // Line noise, tick runs and broken headers; whole frames are pushed apart.
    function automatic void push_random_run(input int target);
        int stop;
        int n;
        int i;
        logic [7:0] b;
        stop = fed_count + target;
        while (fed_count < stop) begin
            case ($urandom_range(0, 2))
                0: begin
                    n = $urandom_range(1, 4);
                    for (i = 0; i < n; i++) begin
                        do
                            b = 8'($urandom_range(0, 255));
                        while (b == SYM_SOH || b == SYM_EOT);
                        push_rx(b);
                    end
                end
                1: begin
                    n = $urandom_range(1, 6);
                    for (i = 0; i < n; i++)
                        push_tick();
                end
                default: begin
                    push_rx(SYM_SOH);
                    if ($urandom_range(0, 1)) begin
                        push_rx(8'(blk_next + 8'($urandom_range(1, 255))));
                    end else begin
                        push_rx(blk_next);
                        push_rx(8'(BLK_ALL - blk_next + 8'($urandom_range(1, 255))));
                    end
                end
            endcase
        end
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        if (idx == CFG_TIMEOUT) begin
            tmo_cfg = val;
        end else if (idx == CFG_LOAD_BASE) begin
            base_cfg = val;
            wr_addr  = val;
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Waits until the block has nothing left to say.
    task automatic settle();
        while (rx_feed.size() != 0 || in_valid || xfer_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial begin : stimulus
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_reg(CFG_TIMEOUT, 32'd3);
        write_reg(CFG_LOAD_BASE, 32'hFFFF_FFC0);
        push_rx(8'h00);
        push_rx(8'hFF);
        push_rx(SYM_NAK);
        push_rx(SYM_ACK);
        repeat (3) push_tick();
        push_tick();
        push_rx(8'h80);
        repeat (3) push_tick();
        push_rx(SYM_SOH);
        push_rx(8'h00);
        push_rx(SYM_SOH);
        push_rx(8'hFF);
        push_rx(SYM_SOH);
        push_rx(8'h01);
        push_rx(8'h00);
        push_rx(SYM_SOH);
        push_rx(8'h01);
        push_rx(8'hFF);
        settle();

        // The word addresses of this block wrap past the top of the address space.
        write_reg(CFG_TIMEOUT, 32'd1);
        write_reg(CFG_LOAD_BASE, 32'hFFFF_FFF0);
        write_reg(CFG_SPARE_LO, $urandom);
        write_reg(CFG_SPARE_HI, $urandom);
        push_frame(1'b1, FILL_RANDOM);
        push_random_run(15);
        settle();

        write_reg(CFG_TIMEOUT, 32'hFFFF_FFFF);
        write_reg(CFG_LOAD_BASE, 32'hFFFF_FFFF);
        push_frame(1'b0, FILL_ONES);
        settle();

        write_reg(CFG_TIMEOUT, 32'($urandom_range(2, 9)));
        write_reg(CFG_LOAD_BASE, $urandom);
        push_random_run(30);
        settle();

        // After the end of transfer nothing may come out, not even a timeout.
        write_reg(CFG_TIMEOUT, 32'd1);
        push_rx(SYM_EOT);
        push_rx(SYM_SOH);
        repeat (3) push_tick();
        push_rx(SYM_EOT);
        push_rx(8'($urandom_range(0, 255)));
        settle();

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Sender: bursts of random length separated by random gaps.
    always @(negedge clk) begin : drive_in
        t_line_item nxt;
        if (!in_valid || in_took) begin
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (rx_feed.size() != 0) begin
                nxt = rx_feed.pop_front();
                in_valid <= 1'b1;
                in_kind  <= nxt.kind;
                in_rx    <= nxt.rx;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: a rotating stall pattern, plus a long hold-off during a block
    // write so that the input side backs up.
    always @(negedge clk) begin : drive_stall
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (holds_done < 2 && xfer_results.size() >= 20 && rx_feed.size() >= 2) begin
            hold_left = LONG_HOLD;
            holds_done++;
            out_stall <= 1'b1;
        end else begin
            stall_tick++;
            case ((stall_tick >> 6) % 4)
                0: out_stall <= 1'b0;
                1: out_stall <= 1'($urandom_range(0, 1));
                2: out_stall <= (stall_tick % 4) != 0;
                default: out_stall <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    always @(posedge clk) begin : observe
        t_xfer want;
        in_took = rst_n && in_valid && !in_stall;
        if (in_took)
            step_receiver(in_kind, in_rx);
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            if (xfer_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got kind %0d tx 0x%0h",
                         $time, res_kind, res_tx);
                $display("%0t: unexpected result, addr 0x%0h word 0x%0h last %0b",
                         $time, res_addr, res_word, res_last);
                fail_count++;
            end else begin
                want = xfer_results.pop_front();
                check_field("result_kind", 32'(res_kind), 32'(want.rkind));
                check_field("tx_byte", 32'(res_tx), 32'(want.tx));
                check_field("mem_addr", res_addr, want.addr);
                check_field("mem_word", res_word, want.word);
                check_field("last", 32'(res_last), 32'(want.last));
            end
        end
    end

    always @(posedge clk) begin : watchdog
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

endmodule
